// ===== rtl/core/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Concurrent assertion helpers shared by the lidar projection RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/lpsp_pkg.sv =====
// ============================================================================
// lpsp_pkg
// Widths, latencies and tables of the lidar spherical projection pipeline.
// ============================================================================
package lpsp_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 1024;

    localparam int COORD_W = 21;
    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int RANGE_W = 21;
    localparam int AZ_W    = 17;
    localparam int NCOL_W  = 13;
    localparam int NROW_W  = 11;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 48;

    // Square root: one result bit per stage.
    localparam int SQRT_STEPS = 29;
    localparam int SQRT_W     = 2 * SQRT_STEPS;
    localparam int SQRT_LAT   = SQRT_STEPS;

    // CORDIC vectoring: pre-rotation stage, iterations, clamp stage.
    localparam int CORDIC_STEPS = 18;
    localparam int CORDIC_W     = 32;
    localparam int ACC_W        = 26;
    localparam int ANG_W        = 25;
    localparam int ANG_FRAC     = 8;
    localparam int ANG_PI       = 8388608;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

    localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        26'sd2097152, 26'sd1238021, 26'sd654136, 26'sd332050, 26'sd166669,
        26'sd83416, 26'sd41718, 26'sd20860, 26'sd10430, 26'sd5215,
        26'sd2608, 26'sd1304, 26'sd652, 26'sd326, 26'sd163,
        26'sd81, 26'sd41, 26'sd20
    };

    // Column division.
    localparam int DIFF_W  = 26;
    localparam int NUM_W   = 39;
    localparam int MAG_W   = NUM_W - 1;
    localparam int DEN_W   = AZ_W + 1 + ANG_FRAC;
    localparam int DIV_LAT = COL_W + 1;

    typedef struct packed {
        logic [COL_W-1:0] q;
        logic             neg;
        logic             ovf;
    } col_res_t;

    typedef enum logic [1:0] {
        CFG_AZ_MIN = 2'd0,
        CFG_AZ_MAX = 2'd1,
        CFG_COLS   = 2'd2,
        CFG_ROWS   = 2'd3
    } cfg_idx_t;

endpackage

// ===== rtl/core/lidar_point_spherical_projection.sv =====
// ============================================================================
// lidar_point_spherical_projection
// Projects a 3D lidar point onto a range image pixel and gives its range.
// ============================================================================
// Throughput: one point per cycle while the output buffer has room; the
// polar path (square root of the radial distance, 29 stages, then a
// 20-stage CORDIC) sets the pipeline depth.
// A two-entry output buffer lets input beats keep entering while a result
// waits; the pipeline stalls only when both entries are full.
// Reset clears all valid bits and the buffer and loads the register defaults.
`include "assert_macros.svh"

module lidar_point_spherical_projection
    import lpsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // Input point stream.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // x_mm[20:0], y_mm[41:21], z_mm[62:42]
    // Result stream.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // column[11:0], row[21:12], range_mm[42:22]
    output logic             m_tuser,   // hit
    // Configuration writes.
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [AZ_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Pipeline layer map. Layer 0 holds the accepted point; the square
    // stage and the sum stage follow. The azimuth CORDIC starts from
    // layer 0, the two square roots from layer 2, the polar CORDIC from
    // the radial root. All paths are aligned to the row layer.
    // ------------------------------------------------------------------
    localparam int THETA_DONE = CORDIC_LAT;
    localparam int NUM_LAYER  = THETA_DONE + 2;
    localparam int COL_DONE   = NUM_LAYER + DIV_LAT;
    localparam int RHO_DONE   = 2 + SQRT_LAT;
    localparam int PHI_DONE   = RHO_DONE + CORDIC_LAT;
    localparam int FINAL      = PHI_DONE + 1;
    localparam int RANGE_DLY  = FINAL - RHO_DONE;
    localparam int COL_DLY    = FINAL - COL_DONE;
    localparam int ZERO_DLY   = FINAL - 2;
    localparam int Z_DLY      = RHO_DONE;
    localparam int ROWV_W     = NROW_W + 1;

    typedef struct packed {
        logic               hit;
        logic [RANGE_W-1:0] range_mm;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
    } out_beat_t;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic signed [AZ_W-1:0] az_min_reg;
    logic signed [AZ_W-1:0] az_max_reg;
    logic [NCOL_W-1:0]      cols_reg;
    logic [NROW_W-1:0]      rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            az_min_reg <= -17'sd32768;
            az_max_reg <= 17'sd32768;
            cols_reg   <= 13'd360;
            rows_reg   <= 11'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_AZ_MIN: az_min_reg <= $signed(cfg_data);
                CFG_AZ_MAX: az_max_reg <= $signed(cfg_data);
                CFG_COLS:   cols_reg   <= cfg_data[NCOL_W-1:0];
                CFG_ROWS:   rows_reg   <= cfg_data[NROW_W-1:0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Every layer advances together while the output
    // buffer has room; valid bits ride along with the data.
    // ------------------------------------------------------------------
    logic [1:0]      cnt_reg;
    logic            en;
    logic            push;
    logic            pop;
    logic            vld_reg [FINAL+1];
    out_beat_t       head_reg;
    out_beat_t       tail_reg;
    out_beat_t       beat;

    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;
    assign push     = en && vld_reg[FINAL];
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= FINAL; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i <= FINAL; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Front end: capture, squares, sums.
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0]   x_reg, y_reg, z_reg;
    logic signed [2*COORD_W-1:0] sq_x, sq_y, sq_z;
    logic [2*COORD_W-2:0]        xx_reg, yy_reg, zz_reg;
    logic [2*COORD_W-1:0]        xy2_reg, r2_reg;

    assign sq_x = x_reg * x_reg;
    assign sq_y = y_reg * y_reg;
    assign sq_z = z_reg * z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= $signed(s_tdata[COORD_W-1:0]);
            y_reg   <= $signed(s_tdata[2*COORD_W-1:COORD_W]);
            z_reg   <= $signed(s_tdata[3*COORD_W-1:2*COORD_W]);
            xx_reg  <= sq_x[2*COORD_W-2:0];
            yy_reg  <= sq_y[2*COORD_W-2:0];
            zz_reg  <= sq_z[2*COORD_W-2:0];
            xy2_reg <= (2*COORD_W)'(xx_reg) + (2*COORD_W)'(yy_reg);
            r2_reg  <= (2*COORD_W)'(xx_reg) + (2*COORD_W)'(yy_reg) + (2*COORD_W)'(zz_reg);
        end
    end

    // ------------------------------------------------------------------
    // Range and radial distance. The radial distance is taken at eight
    // fractional bits so that it matches the scaled z fed to the CORDIC.
    // ------------------------------------------------------------------
    logic [SQRT_STEPS-1:0] range_root;
    logic [SQRT_STEPS-1:0] rho_root;

    lpsp_isqrt u_range_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (SQRT_W'(r2_reg)),
        .root     (range_root)
    );

    lpsp_isqrt u_rho_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand ({xy2_reg, 16'h0000}),
        .root     (rho_root)
    );

    // ------------------------------------------------------------------
    // Azimuth and column. The column is
    // (theta - azimuth_min) * columns / (azimuth_max - azimuth_min),
    // truncated toward zero; a slightly negative value lands on column 0.
    // ------------------------------------------------------------------
    logic signed [ANG_W-1:0]           theta;
    logic signed [DIFF_W-1:0]          diff_reg;
    logic signed [DIFF_W+NCOL_W:0]     num_full;
    logic signed [NUM_W-1:0]           num_reg;
    logic signed [AZ_W:0]              win;
    logic [DEN_W-1:0]                  den;
    col_res_t                          col_res;

    lpsp_cordic u_theta (
        .clk   (clk),
        .en    (en),
        .x_in  (CORDIC_W'($signed({x_reg, 8'h00}))),
        .y_in  (CORDIC_W'($signed({y_reg, 8'h00}))),
        .angle (theta)
    );

    assign num_full = diff_reg * $signed({1'b0, cols_reg});
    assign win      = (AZ_W+1)'(az_max_reg) - (AZ_W+1)'(az_min_reg);
    assign den      = {win, 8'h00};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= DIFF_W'(theta) - DIFF_W'($signed({az_min_reg, 8'h00}));
            num_reg  <= $signed(num_full[NUM_W-1:0]);
        end
    end

    lpsp_coldiv u_coldiv (
        .clk (clk),
        .en  (en),
        .num (num_reg),
        .den (den),
        .res (col_res)
    );

    // ------------------------------------------------------------------
    // Polar angle and row: row = phi * rows / pi with phi in [0, pi].
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] z_d [Z_DLY];
    logic signed [ANG_W-1:0]   phi;
    logic [ANG_W-2:0]          phi_c;
    logic [ANG_W+NROW_W-2:0]   row_prod;
    logic [ROWV_W-1:0]         row_v_reg;

    lpsp_cordic u_phi (
        .clk   (clk),
        .en    (en),
        .x_in  (CORDIC_W'($signed({z_d[Z_DLY-1], 8'h00}))),
        .y_in  (CORDIC_W'($signed({1'b0, rho_root}))),
        .angle (phi)
    );

    assign phi_c    = (phi < 0) ? '0 : phi[ANG_W-2:0];
    assign row_prod = phi_c * rows_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            row_v_reg <= row_prod[ANG_W+NROW_W-2:ANG_W-2];
    end

    // ------------------------------------------------------------------
    // Alignment delay lines.
    // ------------------------------------------------------------------
    logic [RANGE_W-1:0] range_d [RANGE_DLY];
    col_res_t           col_d   [COL_DLY];
    logic               zero_d  [ZERO_DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_d[0]     <= z_reg;
            range_d[0] <= range_root[RANGE_W-1:0];
            col_d[0]   <= col_res;
            zero_d[0]  <= (r2_reg == '0);
            for (int i = 1; i < Z_DLY; i++)
                z_d[i] <= z_d[i-1];
            for (int i = 1; i < RANGE_DLY; i++)
                range_d[i] <= range_d[i-1];
            for (int i = 1; i < COL_DLY; i++)
                col_d[i] <= col_d[i-1];
            for (int i = 1; i < ZERO_DLY; i++)
                zero_d[i] <= zero_d[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Hit decision and result assembly.
    // ------------------------------------------------------------------
    logic     bad_win;
    logic     col_in;
    logic     row_in;
    logic     hit;
    col_res_t col_f;

    assign col_f   = col_d[COL_DLY-1];
    assign bad_win = (az_max_reg <= az_min_reg);
    assign col_in  = !col_f.ovf && (!col_f.neg || (col_f.q == '0))
                     && ({1'b0, col_f.q} < cols_reg);
    assign row_in  = (row_v_reg < {1'b0, rows_reg}) && (row_v_reg < ROWV_W'(MAX_ROWS));
    assign hit     = !zero_d[ZERO_DLY-1] && !bad_win && col_in && row_in;

    assign beat.hit      = hit;
    assign beat.range_mm = range_d[RANGE_DLY-1];
    assign beat.row      = hit ? row_v_reg[ROW_W-1:0] : '0;
    assign beat.column   = hit ? col_f.q : '0;

    // ------------------------------------------------------------------
    // Two-entry output buffer; head_reg drives the result port.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (push && !pop)
            cnt_reg <= cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push && !pop)
        begin
            if (cnt_reg == 2'd0)
                head_reg <= beat;
            else
                tail_reg <= beat;
        end
        else if (pop && !push)
            head_reg <= tail_reg;
        else if (push && pop)
            head_reg <= beat;
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = head_reg.hit;
    assign m_tdata  = {{(OUT_W - RANGE_W - ROW_W - COL_W){1'b0}},
                       head_reg.range_mm, head_reg.row, head_reg.column};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_no_push_when_full, clk, rst_n, !(push && !pop && (cnt_reg == 2'd2)), "output buffer overrun")
    `ASSERT_IMPLY(a_hit_has_range, clk, rst_n, m_tvalid && m_tuser, m_tdata[42:22] != '0, "hit with zero range")
    `ASSERT_IMPLY(a_miss_zero_pixel, clk, rst_n, m_tvalid && !m_tuser, m_tdata[21:0] == '0, "miss with nonzero pixel")

endmodule

// ===== rtl/core/lpsp_isqrt.sv =====
// ============================================================================
// lpsp_isqrt
// Pipelined integer square root, floor result, one root bit per stage.
// ============================================================================
module lpsp_isqrt
    import lpsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [SQRT_W-1:0]     radicand,
    output logic [SQRT_STEPS-1:0] root
);

    logic [SQRT_W-1:0] n_reg  [SQRT_STEPS];
    logic [SQRT_W-1:0] r_reg  [SQRT_STEPS];
    logic [SQRT_W-1:0] n_next [SQRT_STEPS];
    logic [SQRT_W-1:0] r_next [SQRT_STEPS];

    always_comb
    begin
        logic [SQRT_W-1:0] n_cur;
        logic [SQRT_W-1:0] r_cur;
        logic [SQRT_W-1:0] b;
        logic [SQRT_W-1:0] s;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            n_cur = (k == 0) ? radicand : n_reg[(k == 0) ? 0 : k - 1];
            r_cur = (k == 0) ? '0 : r_reg[(k == 0) ? 0 : k - 1];
            b = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
            s = r_cur + b;
            if (n_cur >= s)
            begin
                n_next[k] = n_cur - s;
                r_next[k] = (r_cur >> 1) + b;
            end
            else
            begin
                n_next[k] = n_cur;
                r_next[k] = r_cur >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                n_reg[k] <= n_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign root = r_reg[SQRT_STEPS-1][SQRT_STEPS-1:0];

endmodule

// ===== rtl/core/lpsp_cordic.sv =====
// ============================================================================
// lpsp_cordic
// Pipelined CORDIC vectoring unit giving atan2(y, x) in units of pi/2^23.
// ============================================================================
module lpsp_cordic
    import lpsp_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [CORDIC_W-1:0] x_in,
    input  logic signed [CORDIC_W-1:0] y_in,
    output logic signed [ANG_W-1:0]    angle
);

    localparam logic signed [ACC_W-1:0] PI_ACC   = ACC_W'(ANG_PI);
    localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(ANG_PI / 2);

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ACC_W-1:0]    a_reg [CORDIC_STEPS+1];
    logic                       zero_reg [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0]    angle_reg;
    logic signed [ACC_W-1:0]    a_fin;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Left half plane is turned by a quarter turn first.
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg[0] <= y_in;
                    y_reg[0] <= -x_in;
                    a_reg[0] <= HALF_ACC;
                end
                else
                begin
                    x_reg[0] <= -y_in;
                    y_reg[0] <= x_in;
                    a_reg[0] <= -HALF_ACC;
                end
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                a_reg[0] <= '0;
            end

            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] + ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] - ATAN_TAB[i];
                end
            end

            angle_reg <= ANG_W'(a_fin);
        end
    end

    always_comb
    begin
        if (zero_reg[CORDIC_STEPS])
            a_fin = '0;
        else if (a_reg[CORDIC_STEPS] > PI_ACC)
            a_fin = PI_ACC;
        else if (a_reg[CORDIC_STEPS] < -PI_ACC)
            a_fin = -PI_ACC;
        else
            a_fin = a_reg[CORDIC_STEPS];
    end

    assign angle = angle_reg;

endmodule

// ===== rtl/core/lpsp_coldiv.sv =====
// ============================================================================
// lpsp_coldiv
// Pipelined signed-by-positive division giving a saturating column quotient.
// ============================================================================
module lpsp_coldiv
    import lpsp_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output col_res_t                res
);

    // User holds the configured divisor steady while items flow; unchecked.
    logic [MAG_W-1:0] den_ext;
    logic [MAG_W-1:0] mag;

    logic [MAG_W-1:0] rem_reg  [COL_W+1];
    logic [COL_W-1:0] q_reg    [COL_W+1];
    logic             neg_reg  [COL_W+1];
    logic             ovf_reg  [COL_W+1];
    logic [MAG_W-1:0] rem_next [COL_W];
    logic [COL_W-1:0] q_next   [COL_W];

    assign den_ext = {{(MAG_W - DEN_W){1'b0}}, den};
    assign mag     = (num < 0) ? MAG_W'(-num) : MAG_W'(num);

    always_comb
    begin
        logic [MAG_W-1:0] trial;
        for (int j = 0; j < COL_W; j++)
        begin
            trial = den_ext << (COL_W - 1 - j);
            if (rem_reg[j] >= trial)
            begin
                rem_next[j] = rem_reg[j] - trial;
                q_next[j]   = q_reg[j] | (COL_W'(1) << (COL_W - 1 - j));
            end
            else
            begin
                rem_next[j] = rem_reg[j];
                q_next[j]   = q_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // A quotient that does not fit the column range is flagged.
            rem_reg[0] <= mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= (num < 0);
            ovf_reg[0] <= (mag >= (den_ext << COL_W));
            for (int j = 0; j < COL_W; j++)
            begin
                rem_reg[j+1] <= rem_next[j];
                q_reg[j+1]   <= q_next[j];
                neg_reg[j+1] <= neg_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    assign res.q   = q_reg[COL_W];
    assign res.neg = neg_reg[COL_W];
    assign res.ovf = ovf_reg[COL_W];

endmodule

// ===== test/lidar_point_spherical_projection_checker.sv =====
// ----------------------------------------------------------------------------
// lidar_point_spherical_projection_checker
// Watches the point, result and register channels of the projection block,
// computes the expected pixel and range of each point and compares them.
// ----------------------------------------------------------------------------
module lidar_point_spherical_projection_checker
    import lpsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    input  logic             m_tuser,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [AZ_W-1:0]  cfg_data,
    output int               errors,
    output int               pending,
    output int               hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint HALF_TURN = 64'sd8388608;

    typedef struct {
        logic             hit;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic [20:0]      range_mm;
    } pixel_t;

    localparam longint ARCTAN [18] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860, 10430,
        5215, 2608, 1304, 652, 326, 163, 81, 41, 20
    };

    longint          az_lo;
    longint          az_hi;
    longint unsigned n_cols;
    longint unsigned n_rows;
    pixel_t          pixel_queue[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC: atan2(yv, xv) in units of pi/2^23.
    function automatic longint vector_angle(longint xv, longint yv);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        acc = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            t = xv;
            if (yv >= 0)
            begin
                xv = yv;
                yv = -t;
                acc = HALF_TURN / 2;
            end
            else
            begin
                xv = -yv;
                yv = t;
                acc = -(HALF_TURN / 2);
            end
        end
        for (int i = 0; i < 18; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0)
            begin
                xv += dx;
                yv -= dy;
                acc += ARCTAN[i];
            end
            else
            begin
                xv -= dx;
                yv += dy;
                acc -= ARCTAN[i];
            end
        end
        if (acc > HALF_TURN)
            acc = HALF_TURN;
        if (acc < -HALF_TURN)
            acc = -HALF_TURN;
        return acc;
    endfunction

    function automatic pixel_t project_point(logic [IN_W-1:0] d);
        pixel_t          p;
        longint          x;
        longint          y;
        longint          z;
        longint unsigned xy2;
        longint unsigned r2;
        longint          theta;
        longint          phi;
        longint          rho;
        longint          u;
        longint          v;
        longint unsigned rng;
        x = longint'($signed(d[20:0]));
        y = longint'($signed(d[41:21]));
        z = longint'($signed(d[62:42]));
        xy2 = longint'(x * x) + longint'(y * y);
        r2 = xy2 + longint'(z * z);
        rng = int_sqrt(r2);
        p.hit = 1'b0;
        p.column = '0;
        p.row = '0;
        p.range_mm = rng[20:0];
        if (r2 != 0 && az_hi > az_lo)
        begin
            theta = vector_angle(x * 256, y * 256);
            rho = longint'(int_sqrt(xy2 << 16));
            phi = vector_angle(z * 256, rho);
            u = ((theta - az_lo * 256) * longint'(n_cols)) / ((az_hi - az_lo) * 256);
            if (phi < 0)
                phi = 0;
            v = longint'((longint'(phi) * n_rows) >> 23);
            if (u >= 0 && u < longint'(n_cols) && u < MAX_COLUMNS &&
                v < longint'(n_rows) && v < MAX_ROWS)
            begin
                p.hit = 1'b1;
                p.column = u[COL_W-1:0];
                p.row = v[ROW_W-1:0];
            end
        end
        return p;
    endfunction

    assign pending = pixel_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t e;
        if (!rst_n)
        begin
            az_lo = -32768;
            az_hi = 32768;
            n_cols = 360;
            n_rows = 16;
            pixel_queue.delete();
            errors = 0;
            hits = 0;
        end
        else
        begin
            // Expected result is computed with the registers as they stand
            // before a write on this same edge takes effect.
            if (s_tvalid && s_tready)
                pixel_queue.insert(pixel_queue.size(), project_point(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (pixel_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat hit=%0b data=%h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    e = pixel_queue.pop_front();
                    if (e.hit)
                        hits++;
                    if (m_tuser !== e.hit || m_tdata[11:0] !== e.column ||
                        m_tdata[21:12] !== e.row || m_tdata[42:22] !== e.range_mm)
                    begin
                        errors++;
                        $display("%0t: mismatch expected hit=%0b col=%0d row=%0d range=%0d,",
                                 $time, e.hit, e.column, e.row, e.range_mm,
                                 " actual hit=%0b col=%0d row=%0d range=%0d",
                                 m_tuser, m_tdata[11:0], m_tdata[21:12], m_tdata[42:22]);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_AZ_MIN: az_lo = longint'($signed(cfg_data));
                    CFG_AZ_MAX: az_hi = longint'($signed(cfg_data));
                    CFG_COLS:   n_cols = 64'(cfg_data[NCOL_W-1:0]);
                    CFG_ROWS:   n_rows = 64'(cfg_data[NROW_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== test/tb_lidar_point_spherical_projection.sv =====
// ----------------------------------------------------------------------------
// tb_lidar_point_spherical_projection
// Drives points and register settings into the projection block with random
// idling on both streams; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_lidar_point_spherical_projection;
    import lpsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 70;   // pipeline is 53 deep plus a small buffer

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [AZ_W-1:0]  cfg_data;
    int               errors;
    int               pending;
    int               hits;
    int               points_sent;
    int               settings_used;
    bit               quiet;          // no idling on either stream when set

    lidar_point_spherical_projection uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lidar_point_spherical_projection_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .hits(hits)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // The result side stalls in random bursts, with runs of readiness in
    // between so that stalls land on every pipeline phase.
    initial
    begin
        int n;
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 6);
                m_tready = 1'b0;
                repeat (n) @(negedge clk);
                m_tready = 1'b1;
            end
        end
    end

    // One point beat: an optional idle burst, then valid held until accepted.
    task automatic send_point(logic signed [20:0] x, logic signed [20:0] y,
                              logic signed [20:0] z);
        int n;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 6);
            s_tvalid = 1'b0;
            repeat (n) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {1'b0, z, y, x};
        do
            @(posedge clk);
        while (!s_tready);
        points_sent++;
    endtask

    task automatic idle_sender();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Registers change only once every result is back and the pipe is empty.
    task automatic write_reg(cfg_idx_t idx, logic [AZ_W-1:0] value);
        idle_sender();
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_window(int lo, int hi, int cols, int rows);
        write_reg(CFG_AZ_MIN, AZ_W'(lo));
        write_reg(CFG_AZ_MAX, AZ_W'(hi));
        write_reg(CFG_COLS, AZ_W'(cols));
        write_reg(CFG_ROWS, AZ_W'(rows));
        settings_used++;
    endtask

    // Mix of full-scale points, close-range points and points on axes or
    // at the coordinate limits.
    function automatic logic [20:0] pick_coord(int style);
        case (style)
            0: return 21'($urandom);
            1: return 21'($urandom_range(0, 4000) - 2000);
            2: return $urandom_range(0, 1) ? 21'h100000 : 21'h0FFFFF;
            default: return 21'd0;
        endcase
    endfunction

    task automatic random_points(int count);
        int style;
        repeat (count)
        begin
            style = $urandom_range(0, 9);
            if (style < 5)
                send_point(pick_coord(0), pick_coord(0), pick_coord(0));
            else if (style < 8)
                send_point(pick_coord(1), pick_coord(1), pick_coord(1));
            else
                send_point(pick_coord($urandom_range(0, 3)),
                           pick_coord($urandom_range(0, 3)),
                           pick_coord($urandom_range(0, 3)));
        end
    endtask

    initial
    begin
        quiet = 1'b0;
        points_sent = 0;
        settings_used = 1;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_AZ_MIN;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed points under the reset window: zero range, z axis,
        // both pre-rotation quadrants, axis directions and coordinate limits.
        send_point(0, 0, 0);
        send_point(0, 0, 1000);
        send_point(0, 0, -1000);
        send_point(0, 0, 21'sh100000);
        send_point(1000, 0, 0);
        send_point(-1000, 0, 0);
        send_point(0, 1000, 0);
        send_point(0, -1000, 0);
        send_point(-1000, 500, 300);
        send_point(-1000, -500, -300);
        send_point(1000, 1000, 0);
        send_point(21'sh0FFFFF, 21'sh0FFFFF, 21'sh0FFFFF);
        send_point(21'sh100000, 21'sh100000, 21'sh100000);
        send_point(21'sh100000, 21'sh0FFFFF, 21'sh100000);
        send_point(21'sh0FFFFF, 21'sh100000, 21'sh0FFFFF);
        send_point(21'sh100000, -1, 5);
        send_point(21'sh100000, 0, 5);
        send_point(1, 0, 0);
        send_point(-1, -1, -1);
        random_points(250);

        // Largest image over the full circle.
        set_window(-32768, 32768, 4096, 1024);
        random_points(250);

        // The sender holds off until every result has come back.
        idle_sender();
        wait (pending == 0);

        // Narrow front-facing window, so many points fall outside it.
        set_window(-4096, 4096, 1000, 64);
        random_points(200);

        // Bad window: maximum not above minimum.
        set_window(1000, 1000, 360, 16);
        random_points(60);
        set_window(32768, -32768, 360, 16);
        random_points(60);

        // Single pixel image, then zero columns and rows.
        set_window(-32768, 32768, 1, 1);
        random_points(100);
        set_window(-32768, 32768, 0, 0);
        random_points(60);

        // Out-of-range register values used as written; all size bits set first.
        set_window(-65536, 65535, 8191, 2047);
        random_points(150);
        set_window(0, 65535, 5000, 1500);
        random_points(150);

        // Random register settings; a wrapped window yields only misses.
        repeat (4)
        begin
            set_window($urandom_range(0, 65536) - 32768, $urandom_range(0, 65536) - 32768,
                       $urandom_range(1, 8191), $urandom_range(1, 2047));
            random_points(100);
        end

        // Last stretch runs with both streams always ready.
        set_window(-16384, 32768, 2048, 512);
        quiet = 1'b1;
        random_points(300);
        idle_sender();

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d points over %0d register settings, %0d of them hits.",
                 points_sent, settings_used, hits);
        if (errors == 0)
            $display("lidar_point_spherical_projection verification clean");
        else
            $display("lidar_point_spherical_projection verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Run stopped on timeout with %0d results outstanding.", pending);
        $display("lidar_point_spherical_projection verification failed");
        $finish;
    end

endmodule
